### design/md5_message_digest_macros.svh
// assertion macros for the md5 message digest checker
// no dependencies
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MD5_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/md5_pkg.sv
// md5 package: constants, round tables, controller/datapath command and status types
// no dependencies
`default_nettype none
package md5_pkg;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic        OpData = 1'b0;
  localparam logic        OpFinish = 1'b1;

  function automatic logic [31:0] step_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] step_rot(input logic [5:0] i);
    logic [4:0] r [16];
    r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return r[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [3:0] step_g(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

  typedef struct packed {
    logic       wr_byte;
    logic [5:0] wr_pos;
    logic [7:0] wr_data;
    logic       wr_len;
    logic       round;
    logic [5:0] round_idx;
    logic       load_work;
    logic       fold;
    logic       init;
    logic       count_inc;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } md5_stat_t;
endpackage
`default_nettype wire

### design/md5_message_digest.sv
// md5 message digest top level: controller, datapath and digest output register
// depends on md5_pkg, md5_ctrl, md5_datapath
//
// usage: s_axis carries one item per byte (tuser = op: 0 data, 1 finish).
// the 64th byte of a block starts a compression (one round per cycle in the
// shared round unit plus load/fold) during which s_axis_tready is low. a
// finish item pads with a byte sweep, writes the length and compresses; when
// fewer than 8 bytes remained, the first block is compressed without the
// length and a second padding sweep writes the length and compresses. the
// digest is registered in the output state after the last fold, stays on m_axis
// until taken; no new item is taken while a digest waits.
// reset clears the chaining words to the md5 initial values and the byte
// count to zero; the block store is not cleared, every byte is written
// before it is read.
`default_nettype none
module md5_message_digest import md5_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // data_byte[7:0]
  input  wire logic         s_axis_tuser,  // op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata   // digest_d, digest_c, digest_b, digest_a (msb first)
);
  md5_cmd_t    cmd;
  md5_stat_t   stat;
  logic [31:0] ca, cb, cc, cd;
  logic [127:0] dig_q;

  md5_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tuser), .in_byte_i(s_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  md5_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .chain_a_o(ca), .chain_b_o(cb), .chain_c_o(cc), .chain_d_o(cd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.init) dig_q <= {cd, cc, cb, ca};
  end

  assign m_axis_tdata = dig_q;
endmodule
`default_nettype wire

### design/md5_datapath.sv
// md5 datapath: block store memory, byte count, chaining and working registers
// depends on md5_pkg
`default_nettype none
module md5_datapath import md5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire md5_cmd_t    cmd_i,
  output md5_stat_t        stat_o,
  output logic [31:0]      chain_a_o,
  output logic [31:0]      chain_b_o,
  output logic [31:0]      chain_c_o,
  output logic [31:0]      chain_d_o
);
  logic [31:0] mem [16];
  logic [31:0] rd_q;
  logic [60:0] count_q;
  logic [31:0] ca_q, cb_q, cc_q, cd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] f, sum, rot;
  logic [4:0]  r;
  logic [63:0] bits;
  logic [5:0]  pos;

  assign pos = count_q[5:0];
  assign bits = {count_q, 3'b000};

  // byte writes, length words, and the registered message word read
  // during rounds the read looks one step ahead
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      mem[cmd_i.wr_pos[5:2]][8*cmd_i.wr_pos[1:0] +: 8] <= cmd_i.wr_data;
    end else if (cmd_i.wr_len) begin
      mem[4'd14] <= bits[31:0];
      mem[4'd15] <= bits[63:32];
    end
    rd_q <= mem[step_g(cmd_i.round ? cmd_i.round_idx + 6'd1 : cmd_i.round_idx)];
  end

  always_comb begin
    unique case (cmd_i.round_idx[5:4])
      2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
      2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + f + rd_q + step_k(cmd_i.round_idx);
    r = step_rot(cmd_i.round_idx);
    rot = (sum << r) | (sum >> (6'd32 - {1'b0, r}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ca_q <= InitA;
      cb_q <= InitB;
      cc_q <= InitC;
      cd_q <= InitD;
    end else begin
      if (cmd_i.init) begin
        count_q <= '0;
        ca_q <= InitA;
        cb_q <= InitB;
        cc_q <= InitC;
        cd_q <= InitD;
      end else begin
        if (cmd_i.count_inc) count_q <= count_q + 61'd1;
        if (cmd_i.fold) begin
          ca_q <= ca_q + a_q;
          cb_q <= cb_q + b_q;
          cc_q <= cc_q + c_q;
          cd_q <= cd_q + d_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= ca_q;
      b_q <= cb_q;
      c_q <= cc_q;
      d_q <= cd_q;
    end else if (cmd_i.round) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  assign stat_o.pos = pos;
  assign chain_a_o = ca_q;
  assign chain_b_o = cb_q;
  assign chain_c_o = cc_q;
  assign chain_d_o = cd_q;
endmodule
`default_nettype wire

### design/md5_ctrl.sv
// md5 controller: byte intake, padding sweep, round sequencing and output register
// depends on md5_pkg
`default_nettype none
module md5_ctrl import md5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        in_op_i,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire md5_stat_t   stat_i,
  output md5_cmd_t         cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StPad, StLen, StPrime, StRound, StFold, StOut
  } state_e;

  state_e     state_q;
  logic [5:0] pad_q, idx_q;
  logic       fin_q, last_q;

  assign in_ready_o = (state_q == StIdle) && !out_valid_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.round_idx = idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.wr_byte = 1'b1;
          cmd_o.wr_pos = stat_i.pos;
          cmd_o.wr_data = (in_op_i == OpFinish) ? PadByte : in_byte_i;
          cmd_o.count_inc = (in_op_i == OpData);
        end
      end
      StPad: begin
        cmd_o.wr_byte = 1'b1;
        cmd_o.wr_pos = pad_q;
        cmd_o.wr_data = 8'h00;
      end
      StLen: cmd_o.wr_len = 1'b1;
      StPrime: cmd_o.load_work = 1'b1;
      StRound: cmd_o.round = 1'b1;
      StFold: cmd_o.fold = 1'b1;
      StOut: cmd_o.init = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pad_q <= '0;
      idx_q <= '0;
      fin_q <= 1'b0;
      last_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            idx_q <= '0;
            if (in_op_i == OpData) begin
              fin_q <= 1'b0;
              last_q <= 1'b0;
              if (stat_i.pos == 6'd63) state_q <= StPrime;
            end else begin
              fin_q <= 1'b1;
              last_q <= (stat_i.pos < 6'd56);
              pad_q <= stat_i.pos + 6'd1;
              if (stat_i.pos == 6'd63) state_q <= StPrime;
              else state_q <= StPad;
            end
          end
        end
        StPad: begin
          pad_q <= pad_q + 6'd1;
          if (pad_q == 6'd63) state_q <= last_q ? StLen : StPrime;
        end
        StLen: state_q <= StPrime;
        StPrime: state_q <= StRound;
        StRound: begin
          idx_q <= idx_q + 6'd1;
          if (idx_q == 6'd63) state_q <= StFold;
        end
        StFold: begin
          idx_q <= '0;
          if (!fin_q) state_q <= StIdle;
          else if (last_q) state_q <= StOut;
          else begin
            // second block: zeros then length
            last_q <= 1'b1;
            pad_q <= '0;
            state_q <= StPad;
          end
        end
        StOut: begin
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/md5_message_digest_checker.sv
// port-level checker for md5_message_digest, bound to the top level
// depends on md5_message_digest_macros.svh
`default_nettype none
`include "md5_message_digest_macros.svh"
module md5_message_digest_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);
  `MD5_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "digest dropped or changed while stalled")
  `MD5_ASSERT(a_no_in_with_out, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready, "item taken while digest waits")
  `MD5_ASSERT(a_finish_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready && !m_axis_tvalid, "finish did not start padding")
  `MD5_ASSERT_NORST(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid in reset")
endmodule
bind md5_message_digest md5_message_digest_checker u_chk (.*);
`default_nettype wire

### test/md5_message_digest_checker.sv
// md5 digest checker: watches both stream channels, predicts digests, compares
// depends on md5_pkg for the op codes, initial values and pad byte
`default_nettype none
module md5_message_digest_monitor import md5_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [127:0] m_axis_tdata,
  output int                fail_count,
  output int                pending_digests
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int RoundShift [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                     4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]  hash_words [4];
  logic [7:0]   block_bytes [64];
  logic [60:0]  byte_total;
  logic [127:0] digest_queue [$];

  function automatic logic [31:0] rotl(logic [31:0] v, int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, t, sum, w;
    int g;
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = 5 * i + 1; end
        2: begin f = b ^ c ^ d; g = 3 * i + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * i; end
      endcase
      g = g % 16;
      w = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
      sum = a + f + w + RoundK[i];
      t = d; d = c; c = b;
      b = b + rotl(sum, RoundShift[(i / 16) * 4 + i % 4]);
      a = t;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
  endtask

  task automatic restart_message();
    hash_words = '{InitA, InitB, InitC, InitD};
    byte_total = '0;
    foreach (block_bytes[i]) block_bytes[i] = '0;
  endtask

  task automatic absorb_item(logic op, logic [7:0] data);
    int pos;
    logic [63:0] bit_len;
    pos = int'(byte_total[5:0]);
    if (op == OpData) begin
      block_bytes[pos] = data;
      byte_total = byte_total + 1;
      if (pos == 63) compress_block();
    end else begin
      bit_len = {byte_total, 3'b000};
      block_bytes[pos] = PadByte;
      for (int p = pos + 1; p < 64; p++) block_bytes[p] = '0;
      if (pos >= 56) begin
        compress_block();
        foreach (block_bytes[i]) block_bytes[i] = '0;
      end
      for (int k = 0; k < 8; k++) block_bytes[56 + k] = bit_len[8*k +: 8];
      compress_block();
      digest_queue.push_back({hash_words[3], hash_words[2], hash_words[1], hash_words[0]});
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    pending_digests = 0;
    restart_message();
  end

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected digest %h", m_axis_tdata);
        end else begin
          want = digest_queue.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (m_axis_tdata[32*k +: 32] !== want[32*k +: 32]) begin
              fail_count++;
              if (fail_count <= 10)
                $display("digest word %0d: expected %h got %h", k, want[32*k +: 32],
                         m_axis_tdata[32*k +: 32]);
            end
          end
        end
      end
      pending_digests = digest_queue.size();
    end
  end
endmodule
`default_nettype wire

### test/md5_message_digest_tb.sv
// md5 digest testbench top: clock, reset, message stimulus and verdict
// depends on md5_pkg, md5_message_digest and md5_message_digest_monitor
`default_nettype none
module md5_message_digest_tb import md5_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = OpData;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  int           fail_count;
  int           pending_digests;
  int           sent_items = 0;
  bit           calm_phase = 1'b0;

  md5_message_digest DUT (.*);
  md5_message_digest_monitor checker_i (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_item(logic op, logic [7:0] data);
    while (!calm_phase && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_message(int len, int fill);
    for (int i = 0; i < len; i++)
      send_item(OpData, fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
    send_item(OpFinish, 8'($urandom_range(255)));
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 38);
  end

  initial begin
    int waited;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_message(0, 0);
    send_message(1, 8'h00);
    send_message(1, 8'hff);
    send_message(3, -1);
    send_item(OpData, 8'h5a);
    send_item(OpData, 8'ha5);
    send_item(OpFinish, 8'hff);
    send_message(10, -1);
    s_axis_tvalid <= 1'b0;
    while (pending_digests != 0) @(negedge clk_i);
    send_message(55, -1);
    send_message(56, -1);
    send_message(63, -1);
    send_message(64, -1);
    calm_phase = 1'b1;
    send_message(119, -1);
    send_message(120, -1);
    calm_phase = 1'b0;
    while (sent_items < 850) begin
      case ($urandom_range(3))
        0: send_message($urandom_range(8), -1);
        1: send_message(52 + $urandom_range(16), -1);
        default: send_message($urandom_range(40), -1);
      endcase
    end
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_digests != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending_digests == 0) begin
      $display("md5_message_digest_tb: clean");
    end else begin
      $display("md5_message_digest_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("md5_message_digest_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
